// ===== hdl/plre_pkg.sv =====
// Shared types and constants for the pulse level run-length encoder.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package plre_pkg;

    localparam int unsigned RUN_W   = 32;
    localparam int unsigned CYC_W   = 8;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned IDX_W   = 3;

    // Position of the final byte of the escaped (five-byte) form.
    localparam logic [IDX_W-1:0] LONG_LAST_IDX = 3'd4;
    localparam logic [BYTE_W-1:0] ESCAPE_BYTE  = 8'h00;
    localparam logic [RUN_W-1:0]  RUN_MAX      = 32'hFFFF_FFFF;

    typedef struct packed {
        logic             level;
        logic [CYC_W-1:0] cycles;
    } t_in_item;

    typedef struct packed {
        logic [BYTE_W-1:0] code_byte;
        logic              last_byte;
    } t_out_item;

    // A finished run handed from the run tracker to the byte serializer.
    typedef struct packed {
        logic             valid;
        logic [RUN_W-1:0] len;
    } t_run_xfer;

endpackage

// ===== hdl/plre_run_tracker.sv =====
// Level tracking and run accumulation with a one-run hand-off buffer.
// Depends on plre_pkg.
`timescale 1ns / 1ps

module plre_run_tracker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_wdata,
    input  logic               i_in_valid,
    input  plre_pkg::t_in_item i_in_data,
    output logic               o_in_stall,
    output plre_pkg::t_run_xfer o_run,
    input  logic               i_run_take
);
    import plre_pkg::*;

    logic             r_init_level, n_init_level;
    logic             r_cur_level, n_cur_level;
    logic [RUN_W-1:0] r_run_len, n_run_len;
    logic             r_started, n_started;
    logic             r_buf_valid, n_buf_valid;
    logic [RUN_W-1:0] r_buf_len, n_buf_len;

    logic             accept;
    logic             level_change;
    logic             emit;
    logic [RUN_W:0]   sum;

    // The buffer holds one finished run; new items wait unless the
    // serializer takes the buffered run in this cycle.
    assign o_in_stall = r_buf_valid && !i_run_take;
    assign accept     = i_in_valid && !o_in_stall;
    assign level_change = i_in_data.level != r_cur_level;
    assign emit       = accept && level_change && r_started;
    assign sum        = {1'b0, r_run_len} + {{(RUN_W + 1 - CYC_W){1'b0}}, i_in_data.cycles};

    always_comb begin
        n_init_level = r_init_level;
        n_cur_level  = r_cur_level;
        n_run_len    = r_run_len;
        n_started    = r_started;
        n_buf_valid  = r_buf_valid && !i_run_take;
        n_buf_len    = r_buf_len;
        if (i_cfg_we) begin
            n_init_level = i_cfg_wdata;
            if (!r_started) begin
                n_cur_level = i_cfg_wdata;
            end
        end
        if (accept) begin
            if (level_change) begin
                n_started   = 1'b1;
                n_cur_level = i_in_data.level;
                n_run_len   = {{(RUN_W - CYC_W){1'b0}}, i_in_data.cycles};
            end else if (sum[RUN_W]) begin
                n_run_len = RUN_MAX;
            end else begin
                n_run_len = sum[RUN_W-1:0];
            end
        end
        if (emit) begin
            n_buf_valid = 1'b1;
            n_buf_len   = r_run_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_level <= 1'b0;
            r_cur_level  <= 1'b0;
            r_run_len    <= '0;
            r_started    <= 1'b0;
            r_buf_valid  <= 1'b0;
        end else begin
            r_init_level <= n_init_level;
            r_cur_level  <= n_cur_level;
            r_run_len    <= n_run_len;
            r_started    <= n_started;
            r_buf_valid  <= n_buf_valid;
        end
        r_buf_len <= n_buf_len;
    end

    assign o_run.valid = r_buf_valid;
    assign o_run.len   = r_buf_len;

    // A pending run is neither lost nor altered until the serializer takes it.
    a_buf_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_buf_valid && !i_run_take |=> r_buf_valid && $stable(r_buf_len))
        else $error("run buffer changed before it was taken");

    // Nothing is emitted before the first level change.
    a_no_emit_unstarted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_started |=> !r_buf_valid || $past(r_buf_valid))
        else $error("run emitted before encoding started");

    // Once started, encoding stays started.
    a_started_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_started |=> r_started)
        else $error("started flag cleared without reset");

endmodule

// ===== hdl/plre_byte_serializer.sv =====
// Turns one finished run into its one-byte or five-byte code stream.
// Depends on plre_pkg.
`timescale 1ns / 1ps

module plre_byte_serializer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  plre_pkg::t_run_xfer i_run,
    output logic                o_run_take,
    output logic                o_out_valid,
    output plre_pkg::t_out_item o_out_data,
    input  logic                i_out_stall
);
    import plre_pkg::*;

    logic             r_busy, n_busy;
    logic             r_long, n_long;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [RUN_W-1:0] r_len, n_len;

    logic              is_last;
    logic              out_take;
    logic [BYTE_W-1:0] byte_sel;

    assign is_last  = !r_long || (r_idx == LONG_LAST_IDX);
    assign out_take = r_busy && !i_out_stall;
    assign o_run_take = i_run.valid && (!r_busy || (out_take && is_last));

    always_comb begin
        byte_sel = ESCAPE_BYTE;
        if (!r_long) begin
            byte_sel = r_len[BYTE_W-1:0];
        end else begin
            unique case (r_idx)
                3'd1:    byte_sel = r_len[7:0];
                3'd2:    byte_sel = r_len[15:8];
                3'd3:    byte_sel = r_len[23:16];
                3'd4:    byte_sel = r_len[31:24];
                default: byte_sel = ESCAPE_BYTE;
            endcase
        end
    end

    always_comb begin
        n_busy = r_busy;
        n_long = r_long;
        n_idx  = r_idx;
        n_len  = r_len;
        if (out_take) begin
            if (is_last) begin
                n_busy = 1'b0;
            end else begin
                n_idx = r_idx + 3'd1;
            end
        end
        if (o_run_take) begin
            n_busy = 1'b1;
            n_idx  = '0;
            n_len  = i_run.len;
            // Zero and anything above one byte take the escaped form.
            n_long = (i_run.len[RUN_W-1:BYTE_W] != '0) || (i_run.len[BYTE_W-1:0] == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else begin
            r_busy <= n_busy;
            r_idx  <= n_idx;
        end
        r_long <= n_long;
        r_len  <= n_len;
    end

    assign o_out_valid          = r_busy;
    assign o_out_data.code_byte = byte_sel;
    assign o_out_data.last_byte = is_last;

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_idx <= LONG_LAST_IDX)
        else $error("byte index out of range");

    a_short_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && !r_long |-> r_idx == '0)
        else $error("short run advanced past its only byte");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_take && is_last && !o_run_take |=> !r_busy)
        else $error("serializer still busy after final byte");

endmodule

// ===== hdl/pulse_level_rle_encoder.sv =====
// Top level of the pulse level run-length encoder.
// Instantiates plre_run_tracker and plre_byte_serializer; uses plre_pkg.
`timescale 1ns / 1ps

// Usage:
// Input channel (i_in_valid, i_in_data, o_in_stall) takes one sample per
// transaction: a level bit and a cycle count. Output channel (o_out_valid,
// o_out_data, i_out_stall) gives one code byte per transaction, with
// last_byte set on the final byte of a run.
// A sample at the current level is absorbed and emits nothing.
// A level change after the first one emits the finished run: one byte for
// 1..255, otherwise an escape byte and four little-endian bytes. The first
// byte appears once the run buffer and then the serializer register the
// run; bytes then leave one per cycle while the receiver does not stall.
// Throughput: one sample per cycle while no run waits; a sample that ends
// a run holds the single run buffer, so a new sample is taken no earlier
// than the cycle in which the byte serializer loads it.
// The configuration write i_cfg_we/i_cfg_wdata sets the initial level.
// Reset clears the initial level, run and started flag; nothing is swept.
// While the receiver stalls, the output byte holds and the run buffer
// fills, after which o_in_stall rises.

module pulse_level_rle_encoder (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_wdata,
    input  logic                i_in_valid,
    input  plre_pkg::t_in_item  i_in_data,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output plre_pkg::t_out_item o_out_data,
    input  logic                i_out_stall
);
    import plre_pkg::*;

    t_run_xfer run_xfer;
    logic      run_take;

    plre_run_tracker u_tracker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_run       (run_xfer),
        .i_run_take  (run_take)
    );

    plre_byte_serializer u_serializer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_run       (run_xfer),
        .o_run_take  (run_take),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule
